@@ rtl/rv32_pkg.sv @@
// Shared types and codes for the RV32IM execute unit.
`default_nettype none
package rv32_pkg;

  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [11:0] CSR_MEPC    = 12'h341;
  localparam logic [11:0] CSR_MCAUSE  = 12'h342;
  localparam logic [11:0] CSR_MSTATUS = 12'h300;
  localparam logic [11:0] CSR_MTVEC   = 12'h305;
  localparam logic [31:0] MRET_STATUS = 32'h80;

  localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;
  localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
  localparam logic [31:0] INSN_MRET   = 32'h3020_0073;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EBREAK = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;
  localparam logic [1:0] ST_BADCSR = 2'd3;

  localparam int QDEPTH = 2;
  localparam int QPTRW  = 1;

  // item kind chosen by the front end
  typedef enum logic [2:0] {
    K_SIMPLE, K_MUL, K_DIV, K_CSR, K_ECALL, K_MRET
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] instruction;
    logic [31:0] pc;
    logic [31:0] rs1_value;
    logic [31:0] rs2_value;
    logic [31:0] load_data;
    logic [31:0] a7_value;
  } qitem_t;

  typedef struct packed {
    logic        rd_write;
    logic [4:0]  rd_index;
    logic [31:0] rd_value;
    logic [31:0] next_pc;
    logic        mem_read;
    logic        mem_write;
    logic [1:0]  mem_size;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
    logic [1:0]  status;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_DIV, S_DIVFIX, S_DONE
  } bstate_t;

endpackage
`default_nettype wire

@@ rtl/rv32_front.sv @@
// Front end: takes items in, classifies them and holds them in a short queue.
`default_nettype none
module rv32_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [191:0]    in_data,
  output logic                 q_valid,
  input  wire logic            q_pop,
  output rv32_pkg::qitem_t     q_head
);
  rv32_pkg::qitem_t       mem [rv32_pkg::QDEPTH];
  logic [rv32_pkg::QPTRW-1:0] wptr, rptr;
  logic [rv32_pkg::QPTRW:0]   count;
  rv32_pkg::qitem_t       it;
  logic [6:0] opc;
  logic       push;

  always_comb begin
    it.instruction = in_data[31:0];
    it.pc          = in_data[63:32];
    it.rs1_value   = in_data[95:64];
    it.rs2_value   = in_data[127:96];
    it.load_data   = in_data[159:128];
    it.a7_value    = in_data[191:160];
    opc = in_data[6:0];
    it.kind = rv32_pkg::K_SIMPLE;
    if (opc == rv32_pkg::OPC_OP && in_data[31:25] == 7'd1) begin
      it.kind = in_data[14] ? rv32_pkg::K_DIV : rv32_pkg::K_MUL;
    end else if (opc == rv32_pkg::OPC_SYSTEM) begin
      if (in_data[14:12] == 3'd1 || in_data[14:12] == 3'd2) it.kind = rv32_pkg::K_CSR;
      else if (in_data[31:0] == rv32_pkg::INSN_ECALL) it.kind = rv32_pkg::K_ECALL;
      else if (in_data[31:0] == rv32_pkg::INSN_MRET) it.kind = rv32_pkg::K_MRET;
    end
  end

  assign in_ready = count != (rv32_pkg::QPTRW+1)'(rv32_pkg::QDEPTH);
  assign push     = in_valid && in_ready;
  assign q_valid  = count != '0;
  assign q_head   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= it;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (q_pop) rptr <= rptr + 1'b1;
      count <= count + (rv32_pkg::QPTRW+1)'(push) - (rv32_pkg::QPTRW+1)'(q_pop);
    end
  end
endmodule
`default_nettype wire

@@ rtl/rv32_divider.sv @@
// Radix-2 restoring divider, one quotient bit a cycle, unsigned magnitudes.
`default_nettype none
module rv32_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient,
  output logic [31:0]      remainder
);
  logic [31:0] q, dsr;
  logic [32:0] r;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] shifted, diff;

  assign shifted = {r[31:0], q[31]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend; dsr <= divisor; r <= '0;
    end else if (busy) begin
      if (!diff[32]) begin
        r <= diff; q <= {q[30:0], 1'b1};
      end else begin
        r <= shifted; q <= {q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; cnt <= '0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; cnt <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q;
  assign remainder = r[31:0];
endmodule
`default_nettype wire

@@ rtl/rv32_back.sv @@
// Back end: executes queued items, owns the CSRs, the multiplier and divider.
`default_nettype none
module rv32_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire rv32_pkg::qitem_t  q_head,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output rv32_pkg::result_t      res
);
  rv32_pkg::bstate_t state, state_next;
  rv32_pkg::qitem_t  cur;
  logic [31:0] mepc, mcause, mstatus, mtvec;

  // decode of the current item
  logic [31:0] ins, pc, a, b;
  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  rv32_pkg::result_t simple, fin;
  logic        wr, taken;
  logic [31:0] val;

  // multiplier: four 16x16 partial products, summed the next cycle
  logic [32:0] ma, mb;           // sign- or zero-extended operands, 33 bits
  logic [32:0] ma_abs, mb_abs;
  logic        mneg;
  logic [31:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [63:0] mprod, mres;

  // divider
  logic        dsgn, dstart, ddone, qneg, rneg;
  logic [31:0] da, db, dq, dr;
  logic [31:0] div_val;

  assign ins = cur.instruction;
  assign pc  = cur.pc;
  assign a   = cur.rs1_value;
  assign b   = cur.rs2_value;
  assign opc = ins[6:0];
  assign f3  = ins[14:12];
  assign f7  = ins[31:25];
  assign rd  = ins[11:7];
  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_u = {ins[31:12], 12'd0};
  assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

  always_comb begin
    simple = '0;
    simple.next_pc = pc + 32'd4;
    simple.status  = rv32_pkg::ST_OK;
    wr = 1'b0; val = '0; taken = 1'b0;
    case (opc)
      rv32_pkg::OPC_LOAD: begin
        wr = 1'b1;
        simple.mem_read = 1'b1;
        simple.mem_address = a + imm_i;
        case (f3)
          3'd0: begin
            simple.mem_size = 2'd0; val = {{24{cur.load_data[7]}}, cur.load_data[7:0]};
          end
          3'd1: begin
            simple.mem_size = 2'd1; val = {{16{cur.load_data[15]}}, cur.load_data[15:0]};
          end
          3'd2: begin simple.mem_size = 2'd2; val = cur.load_data; end
          3'd4: begin simple.mem_size = 2'd0; val = {24'd0, cur.load_data[7:0]}; end
          3'd5: begin simple.mem_size = 2'd1; val = {16'd0, cur.load_data[15:0]}; end
          default: begin
            wr = 1'b0; simple.mem_read = 1'b0; simple.mem_address = '0;
            simple.status = rv32_pkg::ST_ILLEGAL;
          end
        endcase
      end
      rv32_pkg::OPC_STORE: begin
        if (f3 <= 3'd2) begin
          simple.mem_write = 1'b1; simple.mem_size = f3[1:0];
          simple.mem_address = a + imm_s; simple.mem_write_data = b;
        end else simple.status = rv32_pkg::ST_ILLEGAL;
      end
      rv32_pkg::OPC_OPIMM: begin
        wr = 1'b1;
        case (f3)
          3'd0: val = a + imm_i;
          3'd2: val = {31'd0, $signed(a) < $signed(imm_i)};
          3'd3: val = {31'd0, a < imm_i};
          3'd4: val = a ^ imm_i;
          3'd6: val = a | imm_i;
          3'd7: val = a & imm_i;
          3'd1: begin
            if (f7 == 7'd0) val = a << imm_i[4:0];
            else begin wr = 1'b0; simple.status = rv32_pkg::ST_ILLEGAL; end
          end
          default: begin
            if (f7 == 7'd0) val = a >> imm_i[4:0];
            else if (f7 == 7'h20) val = 32'($signed(a) >>> imm_i[4:0]);
            else begin wr = 1'b0; simple.status = rv32_pkg::ST_ILLEGAL; end
          end
        endcase
      end
      rv32_pkg::OPC_OP: begin
        wr = 1'b1;
        if (f7 == 7'd0) begin
          case (f3)
            3'd0: val = a + b;
            3'd1: val = a << b[4:0];
            3'd2: val = {31'd0, $signed(a) < $signed(b)};
            3'd3: val = {31'd0, a < b};
            3'd4: val = a ^ b;
            3'd5: val = a >> b[4:0];
            3'd6: val = a | b;
            default: val = a & b;
          endcase
        end else if (f7 == 7'h20 && f3 == 3'd0) val = a - b;
        else if (f7 == 7'h20 && f3 == 3'd5) val = 32'($signed(a) >>> b[4:0]);
        else begin wr = 1'b0; simple.status = rv32_pkg::ST_ILLEGAL; end
      end
      rv32_pkg::OPC_BRANCH: begin
        case (f3)
          3'd0: taken = a == b;
          3'd1: taken = a != b;
          3'd4: taken = $signed(a) < $signed(b);
          3'd5: taken = $signed(a) >= $signed(b);
          3'd6: taken = a < b;
          3'd7: taken = a >= b;
          default: simple.status = rv32_pkg::ST_ILLEGAL;
        endcase
        if (taken) simple.next_pc = pc + imm_b;
      end
      rv32_pkg::OPC_JAL: begin
        wr = 1'b1; val = pc + 32'd4; simple.next_pc = pc + imm_j;
      end
      rv32_pkg::OPC_JALR: begin
        if (f3 == 3'd0) begin
          wr = 1'b1; val = pc + 32'd4; simple.next_pc = (a + imm_i) & ~32'd1;
        end else simple.status = rv32_pkg::ST_ILLEGAL;
      end
      rv32_pkg::OPC_LUI:   begin wr = 1'b1; val = imm_u; end
      rv32_pkg::OPC_AUIPC: begin wr = 1'b1; val = pc + imm_u; end
      rv32_pkg::OPC_SYSTEM: begin
        if (ins == rv32_pkg::INSN_EBREAK) simple.status = rv32_pkg::ST_EBREAK;
        else simple.status = rv32_pkg::ST_ILLEGAL;
      end
      default: simple.status = rv32_pkg::ST_ILLEGAL;
    endcase
    simple.rd_write = wr && (rd != 5'd0);
    simple.rd_index = simple.rd_write ? rd : 5'd0;
    simple.rd_value = simple.rd_write ? val : 32'd0;
  end

  // multiply operands: mulh signed/signed, mulhsu signed/unsigned, else unsigned
  assign ma = {(f3 == 3'd1 || f3 == 3'd2) && a[31], a};
  assign mb = {(f3 == 3'd1) && b[31], b};
  assign ma_abs = ma[32] ? 33'(-ma) : ma;
  assign mb_abs = mb[32] ? 33'(-mb) : mb;

  always_ff @(posedge clk) begin
    if (state == rv32_pkg::S_MUL1) begin
      pp_ll <= ma_abs[15:0]  * mb_abs[15:0];
      pp_lh <= ma_abs[15:0]  * mb_abs[31:16];
      pp_hl <= ma_abs[31:16] * mb_abs[15:0];
      pp_hh <= ma_abs[31:16] * mb_abs[31:16];
      mneg  <= ma[32] ^ mb[32];
    end
  end
  assign mprod = {pp_hh, 32'd0} + {16'd0, pp_lh, 16'd0} + {16'd0, pp_hl, 16'd0}
               + {32'd0, pp_ll};
  assign mres  = mneg ? 64'(-mprod) : mprod;

  // divider operands and sign fix
  assign dsgn = !f3[0];
  assign da = (dsgn && a[31]) ? 32'(-a) : a;
  assign db = (dsgn && b[31]) ? 32'(-b) : b;
  assign qneg = dsgn && (a[31] != b[31]);
  assign rneg = dsgn && a[31];

  rv32_divider u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(da), .divisor(db),
    .done(ddone), .quotient(dq), .remainder(dr)
  );

  always_comb begin
    if (b == 32'd0) div_val = f3[1] ? a : 32'hFFFF_FFFF;
    else if (f3[1]) div_val = rneg ? 32'(-dr) : dr;
    else div_val = qneg ? 32'(-dq) : dq;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rv32_pkg::S_IDLE: begin
        if (q_valid) begin
          case (q_head.kind)
            rv32_pkg::K_MUL: state_next = rv32_pkg::S_MUL1;
            rv32_pkg::K_DIV: state_next = rv32_pkg::S_DIV;
            default:         state_next = rv32_pkg::S_DONE;
          endcase
        end
      end
      rv32_pkg::S_MUL1:   state_next = rv32_pkg::S_MUL2;
      rv32_pkg::S_MUL2:   state_next = rv32_pkg::S_DONE;
      rv32_pkg::S_DIV:    if (ddone) state_next = rv32_pkg::S_DIVFIX;
      rv32_pkg::S_DIVFIX: state_next = rv32_pkg::S_DONE;
      rv32_pkg::S_DONE:   if (!res_valid || res_ready) state_next = rv32_pkg::S_IDLE;
      default:            state_next = rv32_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  logic dstarted;
  always_comb begin
    q_pop  = (state == rv32_pkg::S_IDLE) && q_valid;
    dstart = (state == rv32_pkg::S_DIV) && !dstarted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rv32_pkg::S_IDLE; dstarted <= 1'b0;
    end else begin
      state <= state_next;
      dstarted <= (state == rv32_pkg::S_DIV) && !ddone;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
  end

  // final result and CSR read
  logic [31:0] csr_old;
  logic        csr_hit;
  always_comb begin
    csr_hit = 1'b1;
    case (ins[31:20])
      rv32_pkg::CSR_MEPC:    csr_old = mepc;
      rv32_pkg::CSR_MCAUSE:  csr_old = mcause;
      rv32_pkg::CSR_MSTATUS: csr_old = mstatus;
      rv32_pkg::CSR_MTVEC:   csr_old = mtvec;
      default: begin csr_old = '0; csr_hit = 1'b0; end
    endcase
    fin = simple;
    case (cur.kind)
      rv32_pkg::K_CSR: begin
        fin.status = csr_hit ? rv32_pkg::ST_OK : rv32_pkg::ST_BADCSR;
        fin.rd_write = csr_hit && (rd != 5'd0);
        fin.rd_index = fin.rd_write ? rd : 5'd0;
        fin.rd_value = fin.rd_write ? csr_old : 32'd0;
      end
      rv32_pkg::K_ECALL: begin fin.status = rv32_pkg::ST_OK; fin.next_pc = mtvec; end
      rv32_pkg::K_MRET:  begin fin.status = rv32_pkg::ST_OK; fin.next_pc = mepc; end
      rv32_pkg::K_MUL, rv32_pkg::K_DIV: begin
        fin.status = rv32_pkg::ST_OK;
        fin.rd_write = rd != 5'd0;
        fin.rd_index = rd;
        fin.rd_value = (rd == 5'd0) ? 32'd0 :
                       (cur.kind == rv32_pkg::K_DIV) ? div_val :
                       (f3 == 3'd0) ? mres[31:0] : mres[63:32];
      end
      default: ;
    endcase
  end

  logic issued;

  // issue into the output register once per item, with the CSR update
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0; issued <= 1'b0;
      mepc <= '0; mcause <= '0; mstatus <= '0; mtvec <= '0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (state == rv32_pkg::S_IDLE) issued <= 1'b0;
      if (state == rv32_pkg::S_DONE && !issued && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
        issued <= 1'b1;
        if (cur.kind == rv32_pkg::K_CSR && csr_hit) begin
          case (ins[31:20])
            rv32_pkg::CSR_MEPC:    mepc    <= f3[1] ? (mepc | a) : a;
            rv32_pkg::CSR_MCAUSE:  mcause  <= f3[1] ? (mcause | a) : a;
            rv32_pkg::CSR_MSTATUS: mstatus <= f3[1] ? (mstatus | a) : a;
            default:               mtvec   <= f3[1] ? (mtvec | a) : a;
          endcase
        end else if (cur.kind == rv32_pkg::K_ECALL) begin
          mepc <= pc; mcause <= cur.a7_value;
        end else if (cur.kind == rv32_pkg::K_MRET) begin
          mstatus <= rv32_pkg::MRET_STATUS;
        end
      end
    end
  end

  // result payload; multiplier and divider outputs stay put until issue
  always_ff @(posedge clk) begin
    if (state == rv32_pkg::S_DONE && !issued && (!res_valid || res_ready)) res <= fin;
  end
endmodule
`default_nettype wire

@@ rtl/rv32im_execute_unit.sv @@
// Top level of the RV32IM execute unit: front queue, back end, stream ports.
// Each item waits in the queue, is popped into the back end and goes through
//   S_MUL1 and S_MUL2 for multiplies, or S_DIV and S_DIVFIX for divides and
//   remainders, on to S_DONE, which registers the result; output stalls hold it
//   there. The back end takes one item at a time, and the radix-2 divider (one
//   quotient bit a cycle) makes divides the slowest items.
// A two-entry queue lets the front accept items while the back end is busy.
// Reset (rst, synchronous) empties the queue, idles the back end and clears
//   mepc, mcause, mstatus and mtvec to zero.
`default_nettype none
module rv32im_execute_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // instruction, pc, rs1_value, rs2_value, load_data, a7_value (lowest first)
  input  wire logic [191:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // rd_write, rd_index, rd_value, next_pc, mem_read, mem_write, mem_size,
  // mem_address, mem_write_data, status (lowest first), zero padded
  output logic [143:0]      m_tdata
);
  logic              q_valid, q_pop;
  rv32_pkg::qitem_t  q_head;
  rv32_pkg::result_t res;

  rv32_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_data(s_tdata), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  rv32_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
  );

  assign m_tdata = {4'd0, res.status, res.mem_write_data, res.mem_address,
                    res.mem_size, res.mem_write, res.mem_read, res.next_pc,
                    res.rd_value, res.rd_index, res.rd_write};

  // x0 never written
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[5:1] != 5'd0)
    else $error("write to x0");
  // load and store never both
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[70] && m_tdata[71]))
    else $error("load and store at once");
  // queue never pops when empty
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
endmodule
`default_nettype wire
